@@ sv/dmcs_pkg.sv @@
// Shared types and constants for the dominant microphone channel selector.
// Used by every module of the block; depends on nothing.
package dmcs_pkg;

  localparam int LANES        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int ENERGY_W     = 48;
  localparam int SQ_W         = 32;
  localparam int SMOOTH_SHIFT = 3;
  localparam int FRAME_W      = LANES * SAMPLE_W;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic RK_DECISION = 1'b0;
  localparam logic RK_SAMPLE   = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] mic_sample_0;
    logic signed [SAMPLE_W-1:0] mic_sample_1;
    logic signed [SAMPLE_W-1:0] mic_sample_2;
    logic signed [SAMPLE_W-1:0] mic_sample_3;
    logic                       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic                       result_kind;
    logic [1:0]                 chosen_channel;
    logic                       channel_switched;
    logic                       capacity_overflow;
    logic signed [SAMPLE_W-1:0] mono_sample;
    logic                       final_sample;
    logic                       nothing_left;
  } out_item_t;

  // Strobes from the sequencer to the energy datapath
  typedef struct packed {
    logic sq_load;
    logic clear_chunk;
    logic clear_avg;
    logic smooth;
  } energy_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_SMOOTH,
    ST_SCAN,
    ST_THRESH,
    ST_DECIDE,
    ST_EMIT,
    ST_READ
  } dmcs_state_t;

endpackage

@@ sv/dmcs_frame_ram.sv @@
// Frame store: one write port, one read port, registered read data.
// Depends on dmcs_pkg for the frame width.
module dmcs_frame_ram
  import dmcs_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [FRAME_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [FRAME_W-1:0] rdata
);

  logic [FRAME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dmcs_energy.sv @@
// Per-channel energy datapath: registered squares, saturating chunk sums and
// the smoothed averages. Depends on dmcs_pkg.
module dmcs_energy
  import dmcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  energy_ctrl_t        ctrl,
  input  logic [2:0]          live_ch,
  input  in_item_t            frame,
  input  logic [1:0]          rd_idx,
  output logic [ENERGY_W-1:0] rd_val
);

  logic signed [SAMPLE_W-1:0] samp     [LANES];
  logic [SQ_W-1:0]            sq       [LANES];
  logic                       sq_valid;
  logic [ENERGY_W-1:0]        chunk_e  [LANES];
  logic [ENERGY_W-1:0]        avg      [LANES];
  logic [ENERGY_W:0]          acc_sum  [LANES];
  logic signed [ENERGY_W:0]   diff     [LANES];
  logic signed [ENERGY_W:0]   sm_new   [LANES];
  logic signed [SQ_W-1:0]     prod     [LANES];
  logic [LANES-1:0]           lane_live;

  assign samp[0] = frame.mic_sample_0;
  assign samp[1] = frame.mic_sample_1;
  assign samp[2] = frame.mic_sample_2;
  assign samp[3] = frame.mic_sample_3;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_live[l] = 3'(l) < live_ch;
      prod[l]      = samp[l] * samp[l];
      acc_sum[l]   = {1'b0, chunk_e[l]} + (ENERGY_W + 1)'(sq[l]);
      diff[l]      = $signed({1'b0, chunk_e[l]}) - $signed({1'b0, avg[l]});
      // floor((e - avg) / 8) is an arithmetic shift of the difference
      sm_new[l]    = $signed({1'b0, avg[l]}) + (diff[l] >>> SMOOTH_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sq_load) begin
      for (int l = 0; l < LANES; l++) begin
        sq[l] <= lane_live[l] ? SQ_W'(unsigned'(prod[l])) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        chunk_e[l] <= '0;
        avg[l]     <= '0;
      end
    end else begin
      sq_valid <= ctrl.sq_load;
      for (int l = 0; l < LANES; l++) begin
        if (ctrl.clear_chunk) begin
          chunk_e[l] <= '0;
        end else if (sq_valid) begin
          chunk_e[l] <= acc_sum[l][ENERGY_W] ? '1 : acc_sum[l][ENERGY_W-1:0];
        end
        if (ctrl.clear_avg) begin
          avg[l] <= '0;
        end else if (ctrl.smooth && lane_live[l]) begin
          avg[l] <= sm_new[l][ENERGY_W-1:0];
        end
      end
    end
  end

  assign rd_val = avg[rd_idx];

endmodule

@@ sv/dominant_mic_channel_selector.sv @@
// Top level of the dominant microphone channel selector: sequencer, chunk
// bookkeeping and output register. Depends on dmcs_pkg, dmcs_energy, dmcs_frame_ram.
//
// Usage
//   in_*  : valid/ready input. operation OP_PUSH adds one frame of the chunk,
//           OP_READ asks for the next mono sample of the dominant channel.
//   out_* : valid/ready result, one register deep. A push without chunk_end
//           gives no result; every other item gives exactly one.
//   cfg_* : channel count write; clears averages, the dominant choice and the
//           open chunk. Taken only while the sequencer is idle.
// Sequencing
//   Plain push: next item taken the following cycle.
//   Chunk-end push: ST_ACC registers the chunk sums, ST_SMOOTH the averages,
//   the loudest-channel scan reads one channel per cycle, then ST_THRESH and
//   ST_DECIDE register the decision; one channel goes straight to ST_EMIT.
//   Read: the frame memory's registered read port feeds the result.
// Reset clears the control state (channel count back to 2) and the energies;
// the frame memory has no reset, the stored-frame count gates every read. A
// stalled receiver holds the result in the output register; the sequencer waits
// for it to drain before it loads the next one and takes no new item meanwhile.
module dominant_mic_channel_selector
  import dmcs_pkg::*;
#(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_FRAMES   = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int AW       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW       = $clog2(MAX_FRAMES + 1);
  localparam int LIVE_MAX = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

  dmcs_state_t         state, state_next;
  logic [2:0]          channel_count;
  logic [2:0]          live_ch;
  logic                multi;
  logic                dom_valid;
  logic [1:0]          dom_index;
  logic [CW-1:0]       stored_frames;
  logic [CW-1:0]       read_position;
  logic                chunk_open;
  logic                chunk_ovf;
  logic [1:0]          scan_idx;
  logic [1:0]          best_idx;
  logic [ENERGY_W-1:0] best_val;
  logic [ENERGY_W:0]   thresh;
  logic [1:0]          res_chosen;
  logic                res_switched;
  logic [1:0]          rd_sel;
  logic                rd_empty;
  logic                rd_final;

  logic                in_acc, cfg_acc, is_push, out_free, out_load;
  logic [CW-1:0]       base;
  logic                room;
  logic                ram_we, ram_re;
  logic [FRAME_W-1:0]  ram_wdata, ram_rdata;
  energy_ctrl_t        ectl;
  logic [1:0]          e_rd_idx;
  logic [ENERGY_W-1:0] e_rd_val;
  logic                take, take_sw;
  logic [1:0]          sel_now;
  logic                empty_now;

  always_comb begin
    if (channel_count == 3'd0) begin
      live_ch = 3'd1;
    end else if (channel_count > 3'(LIVE_MAX)) begin
      live_ch = 3'(LIVE_MAX);
    end else begin
      live_ch = channel_count;
    end
  end

  assign multi     = live_ch > 3'd1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign is_push   = (in_data.operation == OP_PUSH);
  assign out_free  = !out_valid || out_ready;

  // A new chunk starts its frame count over
  assign base      = chunk_open ? stored_frames : '0;
  assign room      = base < CW'(MAX_FRAMES);
  assign ram_we    = in_acc && is_push && room;
  assign ram_re    = in_acc && !is_push;
  assign ram_wdata = {in_data.mic_sample_3, in_data.mic_sample_2,
                      in_data.mic_sample_1, in_data.mic_sample_0};

  assign sel_now   = (multi && dom_valid && ({1'b0, dom_index} < live_ch)) ? dom_index : 2'd0;
  assign empty_now = chunk_open || (read_position >= stored_frames);

  assign ectl.sq_load     = in_acc && is_push;
  assign ectl.clear_chunk = (in_acc && is_push && !chunk_open) || cfg_acc;
  assign ectl.clear_avg   = cfg_acc;
  assign ectl.smooth      = (state == ST_SMOOTH);
  assign e_rd_idx         = (state == ST_THRESH) ? dom_index : scan_idx;

  dmcs_energy u_energy (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ectl),
    .live_ch (live_ch),
    .frame   (in_data),
    .rd_idx  (e_rd_idx),
    .rd_val  (e_rd_val)
  );

  dmcs_frame_ram #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (base[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_position[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sticky switch: first choice, stale index, or a clear 1.5x margin
  always_comb begin
    take    = 1'b0;
    take_sw = 1'b0;
    if (!dom_valid || ({1'b0, dom_index} >= live_ch)) begin
      take    = 1'b1;
      take_sw = !dom_valid || (dom_index != best_idx);
    end else if ((best_idx != dom_index) && ({1'b0, best_val} > thresh)) begin
      take    = 1'b1;
      take_sw = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (!is_push) begin
            state_next = ST_READ;
          end else if (in_data.chunk_end) begin
            state_next = multi ? ST_ACC : ST_EMIT;
          end
        end
      end
      ST_ACC:    state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = ST_SCAN;
      ST_SCAN: begin
        if ({1'b0, scan_idx} == live_ch - 3'd1) begin
          state_next = ST_THRESH;
        end
      end
      ST_THRESH: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_EMIT;
      ST_EMIT, ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd2;
      dom_valid     <= 1'b0;
      dom_index     <= 2'd0;
      stored_frames <= '0;
      read_position <= '0;
      chunk_open    <= 1'b0;
      chunk_ovf     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (in_acc && is_push) begin
        chunk_open <= !in_data.chunk_end;
        if (!chunk_open) begin
          read_position <= '0;
        end
        if (room) begin
          stored_frames <= base + CW'(1);
          chunk_ovf     <= chunk_open ? chunk_ovf : 1'b0;
        end else begin
          stored_frames <= base;
          chunk_ovf     <= 1'b1;
        end
      end else if (in_acc && !empty_now) begin
        read_position <= read_position + CW'(1);
      end

      if (state == ST_DECIDE && take) begin
        dom_index <= best_idx;
        dom_valid <= 1'b1;
      end

      if (cfg_acc) begin
        channel_count <= cfg_data;
        dom_valid     <= 1'b0;
        dom_index     <= 2'd0;
        stored_frames <= '0;
        read_position <= '0;
        chunk_open    <= 1'b0;
        chunk_ovf     <= 1'b0;
      end
    end
  end

  // Scan, decision and read bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc && is_push && in_data.chunk_end) begin
      scan_idx     <= 2'd0;
      res_chosen   <= 2'd0;
      res_switched <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (scan_idx == 2'd0 || e_rd_val > best_val) begin
        best_idx <= scan_idx;
        best_val <= e_rd_val;
      end
      scan_idx <= scan_idx + 2'd1;
    end
    if (state == ST_THRESH) begin
      thresh <= {1'b0, e_rd_val} + {2'b00, e_rd_val[ENERGY_W-1:1]};
    end
    if (state == ST_DECIDE) begin
      res_chosen   <= take ? best_idx : dom_index;
      res_switched <= take_sw;
    end
    if (in_acc && !is_push) begin
      rd_sel   <= sel_now;
      rd_empty <= empty_now;
      rd_final <= (read_position + CW'(1)) == stored_frames;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_READ) begin
        out_data.result_kind       <= RK_SAMPLE;
        out_data.chosen_channel    <= rd_sel;
        out_data.channel_switched  <= 1'b0;
        out_data.capacity_overflow <= 1'b0;
        out_data.mono_sample       <= rd_empty ? '0 : ram_rdata[rd_sel * SAMPLE_W +: SAMPLE_W];
        out_data.final_sample      <= !rd_empty && rd_final;
        out_data.nothing_left      <= rd_empty;
      end else begin
        out_data.result_kind       <= RK_DECISION;
        out_data.chosen_channel    <= res_chosen;
        out_data.channel_switched  <= res_switched;
        out_data.capacity_overflow <= chunk_ovf;
        out_data.mono_sample       <= '0;
        out_data.final_sample      <= 1'b0;
        out_data.nothing_left      <= 1'b0;
      end
    end
  end

  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored_frames <= CW'(MAX_FRAMES))
    else $error("stored frame count beyond capacity");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    read_position <= stored_frames)
    else $error("read position passed the stored frames");

  a_decide_sets_dom: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |=> dom_valid)
    else $error("decision left no dominant channel");

  a_read_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && !rd_empty) |-> (read_position != '0 && !chunk_open))
    else $error("sample read without a consumed stored frame");

endmodule
